[design/cbdsd_pkg.sv]
// Shared types and constants for the CPU bus decoder with sprite DMA.
// Holds the command codes, the item structs and the address map.
// Depends on nothing.
`timescale 1ns / 1ps

package cbdsd_pkg;

  localparam int unsigned RAM_BYTES_DEF = 2048;

  localparam logic [15:0] ADDR_RAM_TOP  = 16'h1FFF;
  localparam logic [15:0] ADDR_PPU_BASE = 16'h2000;
  localparam logic [15:0] ADDR_PPU_TOP  = 16'h3FFF;
  localparam logic [15:0] ADDR_DMA_REG  = 16'h4014;
  localparam logic [15:0] ADDR_PAD0     = 16'h4016;
  localparam logic [15:0] ADDR_PAD1     = 16'h4017;

  localparam int unsigned PHASE_W       = 3;
  localparam logic [PHASE_W-1:0] PHASE_CPU_A = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_CPU_B = 3'd3;
  localparam logic [PHASE_W-1:0] PHASE_LAST  = 3'd5;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_PADS  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        cart_claims;
    logic [7:0]  cart_data;
    logic [7:0]  ppu_data;
    logic        nmi_request;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        cpu_step;
    logic        nmi_out;
    logic        oam_write;
    logic [7:0]  oam_index;
    logic [7:0]  oam_data;
    logic        ppu_read;
    logic        ppu_write;
    logic [2:0]  ppu_register;
    logic        dma_busy;
    logic [15:0] dma_source;
  } out_item_t;

endpackage

[design/cbdsd_chan_if.sv]
// Valid/ready channel carrying one item of a given struct type.
// Used for both the bus input and the result output; no dependencies.
`timescale 1ns / 1ps

interface cbdsd_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

[design/cbdsd_wram.sv]
// Work RAM: single-port-write, registered-read memory with a clearing sweep.
// After reset every entry is written with zero, one per cycle.
// Depends on cbdsd_pkg.
`timescale 1ns / 1ps

module cbdsd_wram import cbdsd_pkg::*; #(
  parameter int unsigned RAM_BYTES = RAM_BYTES_DEF,
  localparam int unsigned RamAw = $clog2(RAM_BYTES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [RamAw-1:0] rd_addr_i,
  input  logic             wr_en_i,
  input  logic [RamAw-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  output logic [7:0]       rd_data_o,
  output logic             clearing_o
);

  logic [7:0]       mem [RAM_BYTES];
  logic [RamAw-1:0] clr_addr_q;
  logic             clearing_q;
  logic [7:0]       rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + RamAw'(1);
      if (clr_addr_q == RamAw'(RAM_BYTES - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_addr_q] <= 8'h00;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clearing_q;

endmodule

[design/cpu_bus_decode_with_sprite_dma.sv]
// Top level: CPU bus decoder with work RAM, controller latches and sprite DMA.
// Depends on cbdsd_pkg, cbdsd_chan_if and cbdsd_wram.
//
// Usage:
//   in_i  carries one bus item: a CPU read, a CPU write, a main-clock tick or
//         a button update. out_o returns exactly one result item per input.
//   The result of every input item is registered and appears on out_o in the
//   following cycle; one item per cycle while in_i.ready stays high.
//   The limit is the work RAM read port, whose data comes in the cycle after
//   the address; out_o takes that data straight from the RAM read register.
//   Every third tick grants a CPU clock or advances the sprite DMA; a DMA
//   copies 256 bytes over at least 1536 ticks plus alignment.
//   After reset the work RAM is cleared, one byte a cycle; in_i.ready stays
//   low until the sweep is done.
//   When the receiver stalls, the result holds in the output register and
//   one further item is not taken until it leaves.
`timescale 1ns / 1ps

module cpu_bus_decode_with_sprite_dma import cbdsd_pkg::*; #(
  parameter int unsigned RAM_BYTES = RAM_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cbdsd_chan_if.sink   in_i,
  cbdsd_chan_if.source out_o
);

  localparam int unsigned RamAw = $clog2(RAM_BYTES);

  function automatic logic [RamAw-1:0] ram_slot(input logic [15:0] a);
    logic [12:0] v;
    v = a[12:0];
    for (int k = 5; k >= 0; k--) begin
      if ((RAM_BYTES << k) < 8192) begin
        if (v >= 13'(RAM_BYTES << k)) begin
          v = v - 13'(RAM_BYTES << k);
        end
      end
    end
    return RamAw'(v);
  endfunction

  in_item_t           it;
  logic               in_fire;
  logic               clearing;
  logic [7:0]         ram_rd_data;
  logic               ram_rd_en;
  logic               ram_wr_en;
  logic [RamAw-1:0]   ram_addr;

  logic [7:0]         pad_buttons_q [2];
  logic [7:0]         pad_buttons_d [2];
  logic [7:0]         pad_shift_q [2];
  logic [7:0]         pad_shift_d [2];
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [7:0]         dma_base_q, dma_base_d;
  logic [7:0]         dma_index_q, dma_index_d;
  logic [7:0]         dma_hold_q;
  logic               dma_aligning_q, dma_aligning_d;
  logic               dma_active_q, dma_active_d;

  logic               res_valid_q;
  out_item_t          res_q, res_d;
  logic               res_use_ram_q, use_ram_d;
  logic               res_dma_ram_q;

  logic               dma_rd, dma_wr, bus_rd;
  logic [15:0]        src;
  logic               in_ram, in_ppu, is_pad, pad_sel;

  assign it      = in_i.item;
  assign in_i.ready = !clearing && (!res_valid_q || out_o.ready);
  assign in_fire = in_i.valid && in_i.ready;

  always_comb begin
    dma_rd = (it.cmd == CMD_TICK) && (phase_q == PHASE_CPU_A)
             && dma_active_q && !dma_aligning_q;
    dma_wr = (it.cmd == CMD_TICK) && (phase_q == PHASE_CPU_B)
             && dma_active_q && !dma_aligning_q;
    bus_rd = (it.cmd == CMD_READ) || dma_rd;
    src    = dma_rd ? {dma_base_q, dma_index_q} : it.address;
    in_ram = src <= ADDR_RAM_TOP;
    in_ppu = (src >= ADDR_PPU_BASE) && (src <= ADDR_PPU_TOP);
    is_pad = (src == ADDR_PAD0) || (src == ADDR_PAD1);
    pad_sel = src[0];
  end

  assign ram_addr  = ram_slot(src);
  assign ram_rd_en = in_fire && bus_rd && !it.cart_claims && in_ram;
  assign ram_wr_en = in_fire && (it.cmd == CMD_WRITE) && !it.cart_claims && in_ram;

  always_comb begin
    res_d          = '0;
    use_ram_d      = 1'b0;
    pad_buttons_d  = pad_buttons_q;
    pad_shift_d    = pad_shift_q;
    phase_d        = phase_q;
    dma_base_d     = dma_base_q;
    dma_index_d    = dma_index_q;
    dma_aligning_d = dma_aligning_q;
    dma_active_d   = dma_active_q;

    if (bus_rd) begin
      if (it.cart_claims) begin
        res_d.read_data = it.cart_data;
      end else if (in_ram) begin
        use_ram_d = 1'b1;
      end else if (in_ppu) begin
        res_d.ppu_read     = 1'b1;
        res_d.ppu_register = src[2:0];
        res_d.read_data    = it.ppu_data;
      end else if (is_pad) begin
        res_d.read_data      = {7'b0, pad_shift_q[pad_sel][7]};
        pad_shift_d[pad_sel] = {pad_shift_q[pad_sel][6:0], 1'b0};
      end else begin
        res_d.read_data = it.cart_data;
      end
    end

    case (it.cmd)
      CMD_WRITE: begin
        if (!it.cart_claims) begin
          if (in_ppu) begin
            res_d.ppu_write    = 1'b1;
            res_d.ppu_register = src[2:0];
          end else if (src == ADDR_DMA_REG) begin
            dma_base_d   = it.write_data;
            dma_index_d  = 8'h00;
            dma_active_d = 1'b1;
          end else if (is_pad) begin
            pad_shift_d[pad_sel] = pad_buttons_q[pad_sel];
          end
        end
      end
      CMD_TICK: begin
        if ((phase_q == PHASE_CPU_A) || (phase_q == PHASE_CPU_B)) begin
          if (!dma_active_q) begin
            res_d.cpu_step = 1'b1;
          end else if (dma_aligning_q) begin
            if (phase_q == PHASE_CPU_B) begin
              dma_aligning_d = 1'b0;
            end
          end else if (dma_wr) begin
            res_d.oam_write = 1'b1;
            res_d.oam_index = dma_index_q;
            res_d.oam_data  = dma_hold_q;
            dma_index_d     = dma_index_q + 8'd1;
            if (dma_index_q == 8'hFF) begin
              dma_active_d   = 1'b0;
              dma_aligning_d = 1'b1;
            end
          end
        end
        res_d.nmi_out = it.nmi_request;
        phase_d = (phase_q == PHASE_LAST) ? '0 : phase_q + PHASE_W'(1);
      end
      CMD_PADS: begin
        pad_buttons_d[it.address[0]] = it.write_data;
      end
      default: begin
      end
    endcase

    res_d.dma_busy   = dma_active_d;
    res_d.dma_source = {dma_base_d, dma_index_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_buttons_q  <= '{default: '0};
      pad_shift_q    <= '{default: '0};
      phase_q        <= '0;
      dma_base_q     <= '0;
      dma_index_q    <= '0;
      dma_aligning_q <= 1'b1;
      dma_active_q   <= 1'b0;
      res_valid_q    <= 1'b0;
      res_use_ram_q  <= 1'b0;
      res_dma_ram_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        pad_buttons_q  <= pad_buttons_d;
        pad_shift_q    <= pad_shift_d;
        phase_q        <= phase_d;
        dma_base_q     <= dma_base_d;
        dma_index_q    <= dma_index_d;
        dma_aligning_q <= dma_aligning_d;
        dma_active_q   <= dma_active_d;
        res_use_ram_q  <= use_ram_d;
        res_dma_ram_q  <= use_ram_d && dma_rd;
        res_valid_q    <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dma_hold_q <= '0;
    end else if (in_fire && dma_rd && !use_ram_d) begin
      dma_hold_q <= res_d.read_data;
    end else if (res_valid_q && res_dma_ram_q) begin
      dma_hold_q <= ram_rd_data;
    end
  end

  always_comb begin
    out_o.item = res_q;
    if (res_use_ram_q) begin
      out_o.item.read_data = ram_rd_data;
    end
  end
  assign out_o.valid = res_valid_q;

  cbdsd_wram #(
    .RAM_BYTES(RAM_BYTES)
  ) u_wram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_addr),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_addr),
    .wr_data_i (it.write_data),
    .rd_data_o (ram_rd_data),
    .clearing_o(clearing)
  );

endmodule

[design/cbdsd_checker.sv]
// Port-level checks for the CPU bus decoder with sprite DMA, bound to the top.
// Depends on cbdsd_pkg and the top level's channel ports.
`timescale 1ns / 1ps

module cbdsd_checker import cbdsd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_item_i
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("result changed while stalled");

  a_step_no_dma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.cpu_step |->
      !out_item_i.dma_busy && !out_item_i.oam_write)
    else $error("cpu clock granted during dma");

  a_ppu_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_item_i.ppu_read && out_item_i.ppu_write))
    else $error("ppu read and write in one item");

  a_oam_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.oam_write |->
      out_item_i.dma_source[7:0] == 8'(out_item_i.oam_index + 8'd1))
    else $error("dma index did not advance after sprite write");

endmodule

bind cpu_bus_decode_with_sprite_dma cbdsd_checker u_cbdsd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_item_i (out_o.item)
);

[tb/tb_cpu_bus_decode_with_sprite_dma.sv]
// Testbench for cpu_bus_decode_with_sprite_dma: directed table, random bus traffic, full DMA run.
// Predicts every result item and checks it against the output channel.
// Depends on cbdsd_pkg, cbdsd_chan_if and the block's RTL.
`timescale 1ns / 1ps

module tb_cpu_bus_decode_with_sprite_dma;
  import cbdsd_pkg::*;

  localparam int RAM_N     = RAM_BYTES_DEF;
  localparam int RND_ITEMS = 1300;

  typedef struct {
    in_item_t  it;
    bit        chk;
    out_item_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  cbdsd_chan_if #(.T(in_item_t))  in_if ();
  cbdsd_chan_if #(.T(out_item_t)) out_if ();

  cpu_bus_decode_with_sprite_dma #(.RAM_BYTES(RAM_N)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predicted bus state
  logic [7:0] ram_img [RAM_N];
  logic [7:0] pad_btn [2];
  logic [7:0] pad_sh  [2];
  logic [2:0] tick_ph;
  logic [7:0] dma_base;
  logic [7:0] dma_idx;
  logic [7:0] dma_hold;
  logic       dma_align;
  logic       dma_on;

  out_item_t  pending_res [$];
  dir_row_t   dir_tab [$];

  int  err_cnt;
  int  n_sent;
  int  n_oam;
  int  n_dma_done;
  int  stall_left;
  bit  idle_on;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int ram_idx(logic [15:0] a);
    return int'(a & ADDR_RAM_TOP) % RAM_N;
  endfunction

  task automatic bus_read_model(input logic [15:0] a, input logic claim,
                                input logic [7:0] cd, input logic [7:0] pd,
                                inout out_item_t r, output logic [7:0] b);
    if (claim) begin
      b = cd;
    end else if (a <= ADDR_RAM_TOP) begin
      b = ram_img[ram_idx(a)];
    end else if (a >= ADDR_PPU_BASE && a <= ADDR_PPU_TOP) begin
      r.ppu_read     = 1'b1;
      r.ppu_register = a[2:0];
      b = pd;
    end else if (a == ADDR_PAD0 || a == ADDR_PAD1) begin
      b = {7'd0, pad_sh[a[0]][7]};
      pad_sh[a[0]] = pad_sh[a[0]] << 1;
    end else begin
      b = cd;
    end
  endtask

  task automatic bus_predict(input in_item_t it, output out_item_t r);
    logic [7:0]  b;
    logic [15:0] a;
    a = it.address;
    r = '0;
    case (it.cmd)
      CMD_READ: begin
        bus_read_model(a, it.cart_claims, it.cart_data, it.ppu_data, r, b);
        r.read_data = b;
      end
      CMD_WRITE: begin
        if (!it.cart_claims) begin
          if (a <= ADDR_RAM_TOP) begin
            ram_img[ram_idx(a)] = it.write_data;
          end else if (a >= ADDR_PPU_BASE && a <= ADDR_PPU_TOP) begin
            r.ppu_write    = 1'b1;
            r.ppu_register = a[2:0];
          end else if (a == ADDR_DMA_REG) begin
            dma_base = it.write_data;
            dma_idx  = 8'd0;
            dma_on   = 1'b1;
          end else if (a == ADDR_PAD0 || a == ADDR_PAD1) begin
            pad_sh[a[0]] = pad_btn[a[0]];
          end
        end
      end
      CMD_TICK: begin
        if (tick_ph == PHASE_CPU_A || tick_ph == PHASE_CPU_B) begin
          if (!dma_on) begin
            r.cpu_step = 1'b1;
          end else if (dma_align) begin
            if (tick_ph == PHASE_CPU_B) dma_align = 1'b0;
          end else if (tick_ph == PHASE_CPU_A) begin
            bus_read_model({dma_base, dma_idx}, it.cart_claims, it.cart_data,
                           it.ppu_data, r, b);
            dma_hold    = b;
            r.read_data = b;
          end else begin
            r.oam_write = 1'b1;
            r.oam_index = dma_idx;
            r.oam_data  = dma_hold;
            n_oam++;
            dma_idx = dma_idx + 8'd1;
            if (dma_idx == 8'd0) begin
              dma_on    = 1'b0;
              dma_align = 1'b1;
              n_dma_done++;
            end
          end
        end
        r.nmi_out = it.nmi_request;
        tick_ph = (tick_ph == PHASE_LAST) ? '0 : tick_ph + 3'd1;
      end
      default: begin
        pad_btn[a[0]] = it.write_data;
      end
    endcase
    r.dma_busy   = dma_on;
    r.dma_source = {dma_base, dma_idx};
  endtask

  function automatic in_item_t mk_item(cmd_e c, logic [15:0] a, logic [7:0] wd, logic cl,
                                       logic [7:0] cd, logic [7:0] pd, logic nmi);
    in_item_t it;
    it.cmd         = c;
    it.address     = a;
    it.write_data  = wd;
    it.cart_claims = cl;
    it.cart_data   = cd;
    it.ppu_data    = pd;
    it.nmi_request = nmi;
    return it;
  endfunction

  function automatic out_item_t mk_res(logic [7:0] rd, logic stp, logic nmi, logic prd,
                                       logic pwr, logic [2:0] rg, logic busy,
                                       logic [15:0] src);
    out_item_t r;
    r              = '0;
    r.read_data    = rd;
    r.cpu_step     = stp;
    r.nmi_out      = nmi;
    r.ppu_read     = prd;
    r.ppu_write    = pwr;
    r.ppu_register = rg;
    r.dma_busy     = busy;
    r.dma_source   = src;
    return r;
  endfunction

  function automatic in_item_t rnd_item(cmd_e c, logic [15:0] a);
    return mk_item(c, a, 8'($urandom), $urandom_range(0, 4) == 0, 8'($urandom),
                   8'($urandom), 1'($urandom));
  endfunction

  function automatic logic [15:0] pick_addr();
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'($urandom_range(0, 16'h1FFF));
      3, 4:    return 16'($urandom_range(16'h2000, 16'h3FFF));
      5:       return $urandom_range(0, 1) ? ADDR_PAD1 : ADDR_PAD0;
      6:       return ADDR_DMA_REG;
      7:       return 16'($urandom_range(16'h4000, 16'h401F));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_row(input in_item_t it, input bit chk, input out_item_t want);
    dir_row_t row;
    row.it   = it;
    row.chk  = chk;
    row.want = want;
    dir_tab.push_back(row);
  endtask

  // Hold the item until accepted, then record its expected result.
  task automatic drive_item(input in_item_t it, input bit chk, input out_item_t want);
    out_item_t r;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.item  <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    bus_predict(it, r);
    pending_res.push_back(chk ? want : r);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic send(input in_item_t it);
    drive_item(it, 1'b0, '0);
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      out_if.ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 5);
      out_if.ready  <= 1'b0;
    end else begin
      out_if.ready  <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.item;
      if (pending_res.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result item: rd=%h src=%h", got.read_data,
                                    got.dma_source);
      end else begin
        want = pending_res.pop_front();
        if (got.read_data !== want.read_data || got.cpu_step !== want.cpu_step ||
            got.nmi_out !== want.nmi_out || got.oam_write !== want.oam_write ||
            got.oam_index !== want.oam_index || got.oam_data !== want.oam_data ||
            got.ppu_read !== want.ppu_read || got.ppu_write !== want.ppu_write ||
            got.ppu_register !== want.ppu_register || got.dma_busy !== want.dma_busy ||
            got.dma_source !== want.dma_source) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("mismatch at %0t: rd step nmi oamw idx dat prd pwr reg busy src", $time);
            $display("  expected %h %b %b %b %h %h %b %b %0d %b %h", want.read_data,
                     want.cpu_step, want.nmi_out, want.oam_write, want.oam_index,
                     want.oam_data, want.ppu_read, want.ppu_write, want.ppu_register,
                     want.dma_busy, want.dma_source);
            $display("  actual   %h %b %b %b %h %h %b %b %0d %b %h", got.read_data,
                     got.cpu_step, got.nmi_out, got.oam_write, got.oam_index,
                     got.oam_data, got.ppu_read, got.ppu_write, got.ppu_register,
                     got.dma_busy, got.dma_source);
          end
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("** cpu_bus_decode_with_sprite_dma: FAILED **");
    $finish;
  end

  initial begin
    logic [15:0] a;
    int          p;
    int          sel;
    int          n;
    int          dir_n;

    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.item   = '0;
    out_if.ready = 1'b0;
    stall_left   = 0;
    idle_on      = 1'b1;
    err_cnt      = 0;
    n_sent       = 0;
    n_oam        = 0;
    n_dma_done   = 0;
    foreach (ram_img[i]) ram_img[i] = 8'd0;
    pad_btn   = '{8'd0, 8'd0};
    pad_sh    = '{8'd0, 8'd0};
    tick_ph   = '0;
    dma_base  = 8'd0;
    dma_idx   = 8'd0;
    dma_hold  = 8'd0;
    dma_align = 1'b1;
    dma_on    = 1'b0;

    add_row(mk_item(CMD_READ,  16'h0000, 8'h00, 1'b0, 8'hA5, 8'h00, 1'b0), 1'b1,
            mk_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000));
    add_row(mk_item(CMD_WRITE, 16'h0000, 8'hFF, 1'b0, 8'h00, 8'h00, 1'b0), 1'b1,
            mk_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000));
    add_row(mk_item(CMD_WRITE, 16'h1FFF, 8'h5A, 1'b0, 8'h00, 8'h00, 1'b0), 1'b1,
            mk_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000));
    add_row(mk_item(CMD_READ,  16'h07FF, 8'h00, 1'b0, 8'hEE, 8'h00, 1'b0), 1'b0, '0);
    add_row(mk_item(CMD_READ,  16'h0800, 8'h00, 1'b0, 8'hEE, 8'h00, 1'b0), 1'b0, '0);
    add_row(mk_item(CMD_READ,  16'h0000, 8'h00, 1'b1, 8'h3C, 8'h00, 1'b0), 1'b1,
            mk_res(8'h3C, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000));
    add_row(mk_item(CMD_WRITE, 16'h0000, 8'h11, 1'b1, 8'h00, 8'h00, 1'b0), 1'b1,
            mk_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000));
    add_row(mk_item(CMD_READ,  16'h2000, 8'h00, 1'b0, 8'h00, 8'h81, 1'b0), 1'b1,
            mk_res(8'h81, 1'b0, 1'b0, 1'b1, 1'b0, 3'd0, 1'b0, 16'h0000));
    add_row(mk_item(CMD_READ,  16'h3FFF, 8'h00, 1'b0, 8'h00, 8'h7E, 1'b0), 1'b1,
            mk_res(8'h7E, 1'b0, 1'b0, 1'b1, 1'b0, 3'd7, 1'b0, 16'h0000));
    add_row(mk_item(CMD_WRITE, 16'h2006, 8'h42, 1'b0, 8'h00, 8'h00, 1'b0), 1'b1,
            mk_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 3'd6, 1'b0, 16'h0000));
    add_row(mk_item(CMD_READ,  16'hFFFF, 8'h00, 1'b0, 8'hC3, 8'h00, 1'b0), 1'b1,
            mk_res(8'hC3, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000));
    add_row(mk_item(CMD_PADS,  16'h0000, 8'h80, 1'b0, 8'h00, 8'h00, 1'b0), 1'b1,
            mk_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000));
    add_row(mk_item(CMD_PADS,  16'h0001, 8'h01, 1'b0, 8'h00, 8'h00, 1'b0), 1'b1,
            mk_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000));
    add_row(mk_item(CMD_WRITE, ADDR_PAD0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0), 1'b1,
            mk_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000));
    add_row(mk_item(CMD_READ,  ADDR_PAD0, 8'h00, 1'b0, 8'hFF, 8'h00, 1'b0), 1'b1,
            mk_res(8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000));
    add_row(mk_item(CMD_READ,  ADDR_PAD0, 8'h00, 1'b0, 8'hFF, 8'h00, 1'b0), 1'b1,
            mk_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000));
    add_row(mk_item(CMD_TICK,  16'h0000, 8'h00, 1'b0, 8'h00, 8'h00, 1'b1), 1'b1,
            mk_res(8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000));
    add_row(mk_item(CMD_TICK,  16'h0000, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0), 1'b1,
            mk_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000));
    add_row(mk_item(CMD_WRITE, ADDR_DMA_REG, 8'h40, 1'b0, 8'h00, 8'h00, 1'b0), 1'b1,
            mk_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 1'b1, 16'h4000));
    for (int k = 0; k < 8; k++)
      add_row(mk_item(CMD_TICK, 16'h0000, 8'h00, 1'b0, 8'h96, 8'h69, k[0]), 1'b0, '0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) drive_item(dir_tab[i].it, dir_tab[i].chk, dir_tab[i].want);
    dir_n = n_sent;

    while (n_sent - dir_n < RND_ITEMS) begin
      idle_on = ($urandom_range(0, 7) != 0);
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        a = pick_addr();
        send(rnd_item(cmd_e'($urandom_range(0, 3)), a));
      end else if (sel < 50) begin
        a = 16'($urandom_range(0, 16'h1FFF));
        send(rnd_item(CMD_WRITE, a));
        n = $urandom_range(1, 3);
        repeat (n) send(rnd_item(CMD_READ, a ^ 16'($urandom_range(0, 3) << 11)));
      end else if (sel < 68) begin
        p = $urandom_range(0, 1);
        send(rnd_item(CMD_PADS, 16'($urandom) & 16'hFFFE | 16'(p)));
        send(mk_item(CMD_WRITE, ADDR_PAD0 | 16'(p), 8'($urandom), 1'b0, 8'($urandom),
                     8'($urandom), 1'b0));
        n = $urandom_range(1, 9);
        repeat (n) send(mk_item(CMD_READ, ADDR_PAD0 | 16'(p), 8'($urandom),
                                $urandom_range(0, 7) == 0, 8'($urandom),
                                8'($urandom), 1'b0));
      end else if (sel < 84) begin
        n = $urandom_range(6, 30);
        repeat (n) send(rnd_item(CMD_TICK, 16'($urandom)));
      end else begin
        case ($urandom_range(0, 3))
          0:       a = {8'($urandom_range(0, 16'h1F)), 8'h00};
          1:       a = {8'($urandom_range(16'h20, 16'h3F)), 8'h00};
          2:       a = 16'h4000;
          default: a = {8'($urandom), 8'h00};
        endcase
        send(mk_item(CMD_WRITE, ADDR_DMA_REG, a[15:8], 1'b0, 8'($urandom), 8'($urandom),
                     1'b0));
        n = $urandom_range(10, 80);
        repeat (n) send(rnd_item(CMD_TICK, 16'($urandom)));
      end
    end

    // Prime both pads, then run one full transfer from the I/O page without idling.
    idle_on = 1'b0;
    send(rnd_item(CMD_PADS, 16'h0000));
    send(rnd_item(CMD_PADS, 16'h0001));
    send(mk_item(CMD_WRITE, ADDR_PAD0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0));
    send(mk_item(CMD_WRITE, ADDR_PAD1, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0));
    send(mk_item(CMD_WRITE, ADDR_DMA_REG, 8'h40, 1'b0, 8'h00, 8'h00, 1'b0));
    while (dma_on) begin
      if ($urandom_range(0, 9) == 0)
        send(rnd_item($urandom_range(0, 1) ? CMD_READ : CMD_WRITE,
                      16'($urandom_range(0, 16'h1FFF))));
      else
        send(rnd_item(CMD_TICK, 16'($urandom)));
    end
    in_if.valid <= 1'b0;

    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (pending_res.size() != 0) err_cnt++;

    $display("Covered %0d bus items, %0d sprite bytes copied, %0d complete transfers.",
             n_sent, n_oam, n_dma_done);
    $display("Errors found: %0d", err_cnt);
    if (err_cnt == 0) begin
      $display("** cpu_bus_decode_with_sprite_dma: PASSED **");
    end else begin
      $display("** cpu_bus_decode_with_sprite_dma: FAILED **");
    end
    $finish;
  end

endmodule
